// ----- rtl/core/table_search_linear_interp_defines.svh -----
// Assertion macros shared by the RTL that checks itself.
`ifndef TABLE_SEARCH_LINEAR_INTERP_DEFINES_SVH
`define TABLE_SEARCH_LINEAR_INTERP_DEFINES_SVH
`ifndef SYNTHESIS
// Assert a property on the rising clock edge, disabled during reset.
`define TSLI_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Assert that the consequent holds whenever the antecedent does.
`define TSLI_ASSERT_IMP(label, ante, cons, msg) \
  `TSLI_ASSERT(label, (ante) |-> (cons), msg)
`else
`define TSLI_ASSERT(label, prop, msg)
`define TSLI_ASSERT_IMP(label, ante, cons, msg)
`endif
`endif

// ----- rtl/core/tsli_pkg.sv -----
package tsli_pkg;

  // Default table size and fixed field widths.
  localparam int unsigned TableDepthDef = 1024;
  localparam int unsigned CfgW          = 11;
  localparam int unsigned IdxInW        = 10;
  localparam int unsigned QuotW         = 34;
  localparam int unsigned DivCntW       = 6;

  // Opcodes of an input word.
  localparam logic OPC_LOAD  = 1'b0;
  localparam logic OPC_QUERY = 1'b1;

  // Lookup status codes.
  localparam logic [1:0] ST_INTERP = 2'd0;
  localparam logic [1:0] ST_BELOW  = 2'd1;
  localparam logic [1:0] ST_ABOVE  = 2'd2;
  localparam logic [1:0] ST_EXACT  = 2'd3;

  // Datapath operations issued by the controller.
  typedef enum logic [4:0] {
    OP_IDLE,
    OP_ACCEPT,
    OP_RD_ENDS,
    OP_CLASSIFY,
    OP_RD_ENTRY,
    OP_FILL_ENTRY,
    OP_SRCH_RD,
    OP_SRCH_CMP,
    OP_RD_K,
    OP_RD_K1,
    OP_CAP_K1,
    OP_PREP,
    OP_MUL,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_FIN,
    OP_EMIT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } cmd_t;

  typedef struct packed {
    logic load_item;
    logic below;
    logic above;
    logic eq_first;
    logic eq_last;
    logic srch_more;
    logic hit;
    logic div_last;
    logic lane_last;
  } sts_t;

endpackage

// ----- rtl/core/tsli_chan_if.sv -----
// Input channel: one load or query word.
interface tsli_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [9:0]  entry_index;
  logic [31:0] time_stamp;
  logic [31:0] azimuth;
  logic [31:0] slant_range;
  logic [31:0] elevation;
  logic [31:0] radial_speed;
  logic [15:0] probe_number;
  logic [15:0] point_id;
  logic [15:0] track_id;

  modport source (
    output valid, opcode, entry_index, time_stamp, azimuth, slant_range, elevation,
           radial_speed, probe_number, point_id, track_id,
    input  ready
  );
  modport sink (
    input  valid, opcode, entry_index, time_stamp, azimuth, slant_range, elevation,
           radial_speed, probe_number, point_id, track_id,
    output ready
  );
endinterface

// Output channel: one lookup result word.
interface tsli_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_time;
  logic [31:0] out_azimuth;
  logic [31:0] out_slant_range;
  logic [31:0] out_elevation;
  logic [31:0] out_radial_speed;
  logic [15:0] out_probe_number;
  logic [15:0] out_point_id;
  logic [15:0] out_track_id;
  logic [1:0]  lookup_status;

  modport source (
    output valid, out_time, out_azimuth, out_slant_range, out_elevation,
           out_radial_speed, out_probe_number, out_point_id, out_track_id,
           lookup_status,
    input  ready
  );
  modport sink (
    input  valid, out_time, out_azimuth, out_slant_range, out_elevation,
           out_radial_speed, out_probe_number, out_point_id, out_track_id,
           lookup_status,
    output ready
  );
endinterface

// ----- rtl/core/tsli_ctrl.sv -----
module tsli_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  tsli_pkg::sts_t sts_i,
  output tsli_pkg::cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_ENDS,
    S_CLASSIFY,
    S_RD_ENTRY,
    S_FILL_ENTRY,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_RD_K,
    S_RD_K1,
    S_CAP_K1,
    S_PREP,
    S_MUL,
    S_DIV_INIT,
    S_DIV_STEP,
    S_FIN,
    S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   emit;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign emit        = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  // Operation for the datapath in each state.
  always_comb begin
    case (state_q)
      S_IDLE:       cmd_o.op = in_valid_i ? tsli_pkg::OP_ACCEPT : tsli_pkg::OP_IDLE;
      S_RD_ENDS:    cmd_o.op = tsli_pkg::OP_RD_ENDS;
      S_CLASSIFY:   cmd_o.op = tsli_pkg::OP_CLASSIFY;
      S_RD_ENTRY:   cmd_o.op = tsli_pkg::OP_RD_ENTRY;
      S_FILL_ENTRY: cmd_o.op = tsli_pkg::OP_FILL_ENTRY;
      S_SRCH_RD:    cmd_o.op = tsli_pkg::OP_SRCH_RD;
      S_SRCH_CMP:   cmd_o.op = tsli_pkg::OP_SRCH_CMP;
      S_RD_K:       cmd_o.op = tsli_pkg::OP_RD_K;
      S_RD_K1:      cmd_o.op = tsli_pkg::OP_RD_K1;
      S_CAP_K1:     cmd_o.op = tsli_pkg::OP_CAP_K1;
      S_PREP:       cmd_o.op = tsli_pkg::OP_PREP;
      S_MUL:        cmd_o.op = tsli_pkg::OP_MUL;
      S_DIV_INIT:   cmd_o.op = tsli_pkg::OP_DIV_INIT;
      S_DIV_STEP:   cmd_o.op = tsli_pkg::OP_DIV_STEP;
      S_FIN:        cmd_o.op = tsli_pkg::OP_FIN;
      S_DONE:       cmd_o.op = emit ? tsli_pkg::OP_EMIT : tsli_pkg::OP_IDLE;
      default:      cmd_o.op = tsli_pkg::OP_IDLE;
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = sts_i.load_item ? S_IDLE : S_RD_ENDS;
        end
      end
      S_RD_ENDS:  state_d = S_CLASSIFY;
      S_CLASSIFY: begin
        if (sts_i.below || sts_i.above || sts_i.eq_first || sts_i.eq_last) begin
          state_d = S_RD_ENTRY;
        end else begin
          state_d = S_SRCH_RD;
        end
      end
      S_RD_ENTRY:   state_d = S_FILL_ENTRY;
      S_FILL_ENTRY: state_d = S_DONE;
      S_SRCH_RD:    state_d = sts_i.srch_more ? S_SRCH_CMP : S_RD_K;
      S_SRCH_CMP:   state_d = sts_i.hit ? S_RD_K : S_SRCH_RD;
      S_RD_K:       state_d = S_RD_K1;
      S_RD_K1:      state_d = S_CAP_K1;
      S_CAP_K1:     state_d = S_PREP;
      S_PREP:       state_d = S_MUL;
      S_MUL:        state_d = S_DIV_INIT;
      S_DIV_INIT:   state_d = S_DIV_STEP;
      S_DIV_STEP:   state_d = sts_i.div_last ? S_FIN : S_DIV_STEP;
      S_FIN:        state_d = sts_i.lane_last ? S_DONE : S_PREP;
      S_DONE:       state_d = emit ? S_IDLE : S_DONE;
      default:      state_d = S_IDLE;
    endcase
  end

  // The result register is full from its load until the receiver takes it.
  always_comb begin
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ----- rtl/core/tsli_dp.sv -----
module tsli_dp #(
  parameter int unsigned TABLE_DEPTH = tsli_pkg::TableDepthDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  tsli_pkg::cmd_t            cmd_i,
  output tsli_pkg::sts_t            sts_o,
  input  logic                      cfg_wr_en_i,
  input  logic [tsli_pkg::CfgW-1:0] cfg_wr_data_i,
  input  logic                      opcode_i,
  input  logic [9:0]                entry_index_i,
  input  logic [31:0]               time_stamp_i,
  input  logic [31:0]               azimuth_i,
  input  logic [31:0]               slant_range_i,
  input  logic [31:0]               elevation_i,
  input  logic [31:0]               radial_speed_i,
  input  logic [15:0]               probe_number_i,
  input  logic [15:0]               point_id_i,
  input  logic [15:0]               track_id_i,
  output logic [31:0]               out_time_o,
  output logic [31:0]               out_azimuth_o,
  output logic [31:0]               out_slant_range_o,
  output logic [31:0]               out_elevation_o,
  output logic [31:0]               out_radial_speed_o,
  output logic [15:0]               out_probe_number_o,
  output logic [15:0]               out_point_id_o,
  output logic [15:0]               out_track_id_o,
  output logic [1:0]                lookup_status_o
);

  localparam int unsigned IdxW = $clog2(TABLE_DEPTH);
  localparam logic [tsli_pkg::QuotW-1:0] QuotSat = {2'b01, {(tsli_pkg::QuotW-2){1'b0}}};

  // Reference table: times, two coordinate banks and ids.
  logic [31:0] times_mem  [TABLE_DEPTH];
  logic [63:0] coord_lo_mem [TABLE_DEPTH];
  logic [63:0] coord_hi_mem [TABLE_DEPTH];
  logic [47:0] ids_mem    [TABLE_DEPTH];

  logic [IdxW-1:0] addr_a, addr_b, addr_c, wr_addr;
  logic            wr_en;
  logic [31:0]     rd_a_q, rd_b_q;
  logic [63:0]     rd_lo_q, rd_hi_q;
  logic [47:0]     rd_ids_q;

  logic [tsli_pkg::CfgW-1:0] cfg_q;
  logic [IdxW-1:0]           last;

  // Query and search registers.
  logic [31:0]     q_q;
  logic [47:0]     qids_q;
  logic [IdxW-1:0] l_q, r_q, m_q, k_q, e_q;
  logic [1:0]      stat_q;
  logic [IdxW:0]   sum_lr;
  logic [IdxW-1:0] mid, k_from_l, k_from_m;

  // Interpolation registers.
  logic [31:0]     t0_q, t1_q, b_q;
  logic [31:0]     x0_q [4];
  logic [31:0]     x1_q [4];
  logic [1:0]      lane_q;
  logic [31:0]     ma_q, mdx_q;
  logic            neg_q, deg_q, sat_q;
  logic [63:0]     prod_q;
  logic [31:0]     rem_q;
  logic [tsli_pkg::QuotW-1:0] dvd_q;
  logic [tsli_pkg::DivCntW-1:0] cnt_q;

  // Working result and output registers.
  logic [31:0] res_time_q, out_time_q;
  logic [31:0] res_val_q [4];
  logic [31:0] out_val_q [4];
  logic [47:0] res_ids_q, out_ids_q;
  logic [1:0]  res_stat_q, out_stat_q;

  // Lane arithmetic.
  logic [31:0] xa, xb;
  logic [32:0] dx, da;
  logic [32:0] rem2;
  logic        ge;
  logic [31:0] hi_part;
  logic [tsli_pkg::QuotW-1:0] quot;
  logic [35:0] quot_ext, sum36;
  logic [31:0] lane_res;

  // Entry count clamped to 1 .. TABLE_DEPTH, held as the last index.
  always_comb begin
    if (cfg_q == '0) begin
      last = '0;
    end else if (32'(cfg_q) > 32'(TABLE_DEPTH)) begin
      last = IdxW'(32'(TABLE_DEPTH) - 32'd1);
    end else begin
      last = IdxW'(32'(cfg_q) - 32'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= tsli_pkg::CfgW'(1);
    end else if (cfg_wr_en_i) begin
      cfg_q <= cfg_wr_data_i;
    end
  end

  // Search midpoint and the bracket index kept below the last entry.
  assign sum_lr   = {1'b0, l_q} + {1'b0, r_q};
  assign mid      = sum_lr[IdxW:1];
  assign k_from_l = (l_q == last) ? last - IdxW'(1) : l_q;
  assign k_from_m = (m_q == last) ? last - IdxW'(1) : m_q;

  // Read addresses per operation.
  always_comb begin
    addr_a = '0;
    addr_b = '0;
    addr_c = '0;
    case (cmd_i.op)
      tsli_pkg::OP_RD_ENDS: begin
        addr_b = last;
      end
      tsli_pkg::OP_RD_ENTRY: begin
        addr_a = e_q;
        addr_c = e_q;
      end
      tsli_pkg::OP_SRCH_RD: begin
        addr_a = mid;
        addr_b = mid + IdxW'(1);
      end
      tsli_pkg::OP_RD_K: begin
        addr_a = k_q;
        addr_b = k_q + IdxW'(1);
        addr_c = k_q;
      end
      tsli_pkg::OP_RD_K1: begin
        addr_c = k_q + IdxW'(1);
      end
      default: begin
        addr_a = '0;
      end
    endcase
  end

  // Loads write one slot; a slot beyond the table is dropped.
  assign wr_addr = IdxW'(entry_index_i);
  assign wr_en   = (cmd_i.op == tsli_pkg::OP_ACCEPT) && (opcode_i == tsli_pkg::OPC_LOAD) &&
                   (32'(entry_index_i) < 32'(TABLE_DEPTH));

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      times_mem[wr_addr]    <= time_stamp_i;
      coord_lo_mem[wr_addr] <= {slant_range_i, azimuth_i};
      coord_hi_mem[wr_addr] <= {radial_speed_i, elevation_i};
      ids_mem[wr_addr]      <= {track_id_i, point_id_i, probe_number_i};
    end
    rd_a_q   <= times_mem[addr_a];
    rd_b_q   <= times_mem[addr_b];
    rd_lo_q  <= coord_lo_mem[addr_c];
    rd_hi_q  <= coord_hi_mem[addr_c];
    rd_ids_q <= ids_mem[addr_c];
  end

  // Status to the controller.
  always_comb begin
    sts_o.load_item = (opcode_i == tsli_pkg::OPC_LOAD);
    sts_o.below     = (q_q < rd_a_q);
    sts_o.above     = (rd_b_q < q_q);
    sts_o.eq_first  = (q_q == rd_a_q);
    sts_o.eq_last   = (q_q == rd_b_q);
    sts_o.srch_more = (l_q < r_q);
    sts_o.hit       = (rd_a_q <= q_q) && (q_q <= rd_b_q);
    sts_o.div_last  = (cnt_q == tsli_pkg::DivCntW'(tsli_pkg::QuotW - 1));
    sts_o.lane_last = (lane_q == 2'd3);
  end

  // Lane operands: differences, magnitudes and one restoring division step.
  always_comb begin
    xa       = x0_q[lane_q];
    xb       = x1_q[lane_q];
    dx       = {xb[31], xb} - {xa[31], xa};
    da       = {1'b0, q_q} - {1'b0, t0_q};
    hi_part  = {2'b00, prod_q[63:34]};
    rem2     = {rem_q, dvd_q[tsli_pkg::QuotW-1]};
    ge       = (rem2 >= {1'b0, b_q});
    quot     = (sat_q || (dvd_q > QuotSat)) ? QuotSat : dvd_q;
    quot_ext = {2'b00, quot};
    sum36    = {{4{xa[31]}}, xa} + (neg_q ? (~quot_ext + 36'd1) : quot_ext);
    if (deg_q) begin
      lane_res = xa;
    end else if (!sum36[35] && (sum36[34:31] != 4'b0000)) begin
      lane_res = 32'h7FFF_FFFF;
    end else if (sum36[35] && (sum36[34:31] != 4'b1111)) begin
      lane_res = 32'h8000_0000;
    end else begin
      lane_res = sum36[31:0];
    end
  end

  // Datapath registers, updated per operation.
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      tsli_pkg::OP_ACCEPT: begin
        q_q    <= time_stamp_i;
        qids_q <= {track_id_i, point_id_i, probe_number_i};
      end
      tsli_pkg::OP_CLASSIFY: begin
        l_q <= '0;
        r_q <= last;
        if (sts_o.below) begin
          e_q    <= '0;
          stat_q <= tsli_pkg::ST_BELOW;
        end else if (sts_o.above) begin
          e_q    <= last;
          stat_q <= tsli_pkg::ST_ABOVE;
        end else if (sts_o.eq_first) begin
          e_q    <= '0;
          stat_q <= tsli_pkg::ST_EXACT;
        end else begin
          e_q    <= last;
          stat_q <= tsli_pkg::ST_EXACT;
        end
      end
      tsli_pkg::OP_FILL_ENTRY: begin
        res_time_q   <= rd_a_q;
        res_val_q[0] <= rd_lo_q[31:0];
        res_val_q[1] <= rd_lo_q[63:32];
        res_val_q[2] <= rd_hi_q[31:0];
        res_val_q[3] <= rd_hi_q[63:32];
        res_ids_q    <= rd_ids_q;
        res_stat_q   <= stat_q;
      end
      tsli_pkg::OP_SRCH_RD: begin
        m_q <= mid;
        if (!sts_o.srch_more) begin
          k_q <= k_from_l;
        end
      end
      tsli_pkg::OP_SRCH_CMP: begin
        if (sts_o.hit) begin
          k_q <= k_from_m;
        end else if (rd_b_q < q_q) begin
          l_q <= m_q + IdxW'(1);
        end else begin
          r_q <= m_q;
        end
      end
      tsli_pkg::OP_RD_K1: begin
        t0_q    <= rd_a_q;
        t1_q    <= rd_b_q;
        x0_q[0] <= rd_lo_q[31:0];
        x0_q[1] <= rd_lo_q[63:32];
        x0_q[2] <= rd_hi_q[31:0];
        x0_q[3] <= rd_hi_q[63:32];
      end
      tsli_pkg::OP_CAP_K1: begin
        x1_q[0]    <= rd_lo_q[31:0];
        x1_q[1]    <= rd_lo_q[63:32];
        x1_q[2]    <= rd_hi_q[31:0];
        x1_q[3]    <= rd_hi_q[63:32];
        lane_q     <= 2'd0;
        res_time_q <= q_q;
        res_ids_q  <= qids_q;
        res_stat_q <= tsli_pkg::ST_INTERP;
      end
      tsli_pkg::OP_PREP: begin
        mdx_q <= dx[32] ? 32'(-dx) : dx[31:0];
        ma_q  <= da[32] ? 32'(-da) : da[31:0];
        neg_q <= dx[32] ^ da[32];
        deg_q <= (t1_q <= t0_q);
        b_q   <= t1_q - t0_q;
      end
      tsli_pkg::OP_MUL: begin
        prod_q <= {32'd0, ma_q} * {32'd0, mdx_q};
      end
      tsli_pkg::OP_DIV_INIT: begin
        sat_q <= (hi_part >= b_q);
        rem_q <= hi_part;
        dvd_q <= prod_q[tsli_pkg::QuotW-1:0];
        cnt_q <= '0;
      end
      tsli_pkg::OP_DIV_STEP: begin
        rem_q <= ge ? 32'(rem2 - {1'b0, b_q}) : rem2[31:0];
        dvd_q <= {dvd_q[tsli_pkg::QuotW-2:0], ge};
        cnt_q <= cnt_q + tsli_pkg::DivCntW'(1);
      end
      tsli_pkg::OP_FIN: begin
        res_val_q[lane_q] <= lane_res;
        lane_q            <= lane_q + 2'd1;
      end
      tsli_pkg::OP_EMIT: begin
        out_time_q <= res_time_q;
        out_val_q  <= res_val_q;
        out_ids_q  <= res_ids_q;
        out_stat_q <= res_stat_q;
      end
      default: begin
        cnt_q <= cnt_q;
      end
    endcase
  end

  assign out_time_o         = out_time_q;
  assign out_azimuth_o      = out_val_q[0];
  assign out_slant_range_o  = out_val_q[1];
  assign out_elevation_o    = out_val_q[2];
  assign out_radial_speed_o = out_val_q[3];
  assign out_probe_number_o = out_ids_q[15:0];
  assign out_point_id_o     = out_ids_q[31:16];
  assign out_track_id_o     = out_ids_q[47:32];
  assign lookup_status_o    = out_stat_q;

endmodule

// ----- rtl/core/table_search_linear_interp.sv -----
// Piecewise linear lookup over a time-sorted reference track.
// Input channel in_chan (valid/ready): a load word (opcode 0) writes one table
// slot and gives no result; a query word (opcode 1) gives one result word on
// out_chan. The configuration port sets the number of entries in use; write
// it only while the block is idle.
// A query that falls outside the table or on an endpoint reads that entry and
// returns it; an interior query runs a binary search, one table read pair per
// search step, then works out the four values one after another through the
// bit-serial 34-step divider shared by the four interpolations.
// One item is worked on at a time; a finished result waits in an output
// register, so the next word is accepted while the receiver stalls, and a
// further result waits until the register is taken.
// Reset empties the output register, returns the controller to idle and sets
// the entry count to one. Table contents are not cleared; entries must be
// loaded before they are used.
`include "table_search_linear_interp_defines.svh"

module table_search_linear_interp #(
  parameter int unsigned TABLE_DEPTH = tsli_pkg::TableDepthDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_wr_en_i,
  input  logic [tsli_pkg::CfgW-1:0] cfg_wr_data_i,
  tsli_in_if.sink                   in_chan,
  tsli_out_if.source                out_chan
);

  tsli_pkg::cmd_t cmd;
  tsli_pkg::sts_t sts;

  // Sequencer.
  tsli_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_chan.valid),
    .in_ready_o  (in_chan.ready),
    .out_valid_o (out_chan.valid),
    .out_ready_i (out_chan.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Table, search and interpolation datapath.
  tsli_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .cfg_wr_en_i        (cfg_wr_en_i),
    .cfg_wr_data_i      (cfg_wr_data_i),
    .opcode_i           (in_chan.opcode),
    .entry_index_i      (in_chan.entry_index),
    .time_stamp_i       (in_chan.time_stamp),
    .azimuth_i          (in_chan.azimuth),
    .slant_range_i      (in_chan.slant_range),
    .elevation_i        (in_chan.elevation),
    .radial_speed_i     (in_chan.radial_speed),
    .probe_number_i     (in_chan.probe_number),
    .point_id_i         (in_chan.point_id),
    .track_id_i         (in_chan.track_id),
    .out_time_o         (out_chan.out_time),
    .out_azimuth_o      (out_chan.out_azimuth),
    .out_slant_range_o  (out_chan.out_slant_range),
    .out_elevation_o    (out_chan.out_elevation),
    .out_radial_speed_o (out_chan.out_radial_speed),
    .out_probe_number_o (out_chan.out_probe_number),
    .out_point_id_o     (out_chan.out_point_id),
    .out_track_id_o     (out_chan.out_track_id),
    .lookup_status_o    (out_chan.lookup_status)
  );

  // A load never produces a result word.
  `TSLI_ASSERT_IMP(a_load_no_result, $rose(out_chan.valid), !$past(in_chan.valid && in_chan.ready && (in_chan.opcode == tsli_pkg::OPC_LOAD)), "result appeared after a load word")

  // A query occupies the block, so no word is taken in the next cycle.
  `TSLI_ASSERT_IMP(a_query_busy, in_chan.valid && in_chan.ready && (in_chan.opcode == tsli_pkg::OPC_QUERY), ##1 !in_chan.ready, "word accepted while a query is in progress")

endmodule

// ----- tb/tb_table_search_linear_interp.sv -----
`timescale 1ns / 1ps

module tb_table_search_linear_interp;

  localparam int unsigned Depth = tsli_pkg::TableDepthDef;

  // One input word and one result word, as the predictor sees them.
  typedef struct packed {
    logic        opcode;
    logic [9:0]  entry_index;
    logic [31:0] time_stamp;
    logic [31:0] azimuth;
    logic [31:0] slant_range;
    logic [31:0] elevation;
    logic [31:0] radial_speed;
    logic [15:0] probe_number;
    logic [15:0] point_id;
    logic [15:0] track_id;
  } word_in_t;

  typedef struct packed {
    logic [31:0] tm;
    logic [31:0] az;
    logic [31:0] sr;
    logic [31:0] el;
    logic [31:0] rs;
    logic [15:0] probe;
    logic [15:0] point;
    logic [15:0] track;
    logic [1:0]  status;
  } word_out_t;

  // A row of the directed table; a typed-in status is checked directly.
  typedef struct {
    logic        is_cfg;
    logic [10:0] cfg_val;
    word_in_t    w;
    logic        has_status;
    logic [1:0]  status;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_wr_en_i = 1'b0;
  logic [tsli_pkg::CfgW-1:0] cfg_wr_data_i = '0;

  tsli_in_if  in_chan ();
  tsli_out_if out_chan ();

  table_search_linear_interp i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_wr_en_i  (cfg_wr_en_i),
    .cfg_wr_data_i(cfg_wr_data_i),
    .in_chan      (in_chan),
    .out_chan     (out_chan)
  );

  // Predictor copy of the track table and entry count.
  logic [31:0] track_time [Depth];
  logic [31:0] track_val  [Depth][4];
  logic [15:0] track_ids  [Depth][3];
  int unsigned count_in_use = 1;

  word_out_t   expected_words[$];
  logic [1:0]  typed_status[$];
  logic        typed_valid[$];
  int          mismatches = 0;
  logic        no_stall = 1'b0;
  logic        hold_off = 1'b0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // x0 + trunc((x1-x0)*(q-t0)/(t1-t0)), saturated to 32 bits.
  function automatic logic [31:0] interp_value(logic signed [31:0] x0,
      logic signed [31:0] x1, logic [31:0] t0, logic [31:0] t1, logic [31:0] q);
    longint a, dx, r;
    logic [63:0] ma, mdx, quot, span;
    logic neg;
    if (t1 <= t0) return x0;
    span = {32'd0, t1} - {32'd0, t0};
    a  = longint'({32'd0, q}) - longint'({32'd0, t0});
    dx = longint'(x1) - longint'(x0);
    ma  = a < 0 ? -a : a;
    mdx = dx < 0 ? -dx : dx;
    neg = (dx < 0) != (a < 0);
    quot = (mdx * ma) / span;
    if (quot > 64'd1 << 33) quot = 64'd1 << 33;
    r = longint'(x0) + (neg ? -longint'(quot) : longint'(quot));
    if (r > 64'sh7fffffff) r = 64'sh7fffffff;
    if (r < -64'sh80000000) r = -64'sh80000000;
    return r[31:0];
  endfunction

  function automatic word_out_t stored_entry(int unsigned i, logic [1:0] st);
    word_out_t o;
    o = '{track_time[i], track_val[i][0], track_val[i][1], track_val[i][2],
          track_val[i][3], track_ids[i][0], track_ids[i][1], track_ids[i][2], st};
    return o;
  endfunction

  // Applies one accepted word; returns 1 with the expected result for a query.
  function automatic logic lookup_predict(word_in_t w, output word_out_t o);
    int unsigned n, last, l, r, m, k;
    logic found;
    logic [31:0] q;
    q = w.time_stamp;
    if (w.opcode == tsli_pkg::OPC_LOAD) begin
      track_time[w.entry_index] = q;
      track_val[w.entry_index] = '{w.azimuth, w.slant_range, w.elevation, w.radial_speed};
      track_ids[w.entry_index] = '{w.probe_number, w.point_id, w.track_id};
      return 1'b0;
    end
    n = count_in_use < 1 ? 1 : (count_in_use > Depth ? Depth : count_in_use);
    last = n - 1;
    if (q < track_time[0]) begin
      o = stored_entry(0, tsli_pkg::ST_BELOW);
      return 1'b1;
    end
    if (track_time[last] < q) begin
      o = stored_entry(last, tsli_pkg::ST_ABOVE);
      return 1'b1;
    end
    if (q == track_time[0]) begin
      o = stored_entry(0, tsli_pkg::ST_EXACT);
      return 1'b1;
    end
    if (q == track_time[last]) begin
      o = stored_entry(last, tsli_pkg::ST_EXACT);
      return 1'b1;
    end
    l = 0; r = last; m = 0; found = 1'b0;
    while (l < r) begin
      m = (l + r) / 2;
      if (track_time[m] <= q && q <= track_time[m+1]) begin
        found = 1'b1;
        break;
      end
      if (track_time[m+1] < q) l = m + 1;
      else r = m;
    end
    k = found ? m : l;
    if (k > n - 2) k = n - 2;
    o.tm = q;
    o.az = interp_value(track_val[k][0], track_val[k+1][0], track_time[k], track_time[k+1], q);
    o.sr = interp_value(track_val[k][1], track_val[k+1][1], track_time[k], track_time[k+1], q);
    o.el = interp_value(track_val[k][2], track_val[k+1][2], track_time[k], track_time[k+1], q);
    o.rs = interp_value(track_val[k][3], track_val[k+1][3], track_time[k], track_time[k+1], q);
    o.probe = w.probe_number;
    o.point = w.point_id;
    o.track = w.track_id;
    o.status = tsli_pkg::ST_INTERP;
    return 1'b1;
  endfunction

  // Receiver: random stall bursts, plus the long hold-off when asked.
  initial begin
    int burst;
    out_chan.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off) out_chan.ready <= 1'b0;
      else if (burst > 0) begin
        burst--;
        out_chan.ready <= 1'b0;
      end else if (!no_stall && $urandom_range(0, 9) == 0) begin
        burst = $urandom_range(1, 12) - 1;
        out_chan.ready <= 1'b0;
      end else out_chan.ready <= 1'b1;
    end
  end

  // Result checker: compares each taken word with the oldest expectation.
  always @(posedge clk_i) begin
    word_out_t got, want;
    logic tv;
    logic [1:0] ts;
    if (rst_ni && out_chan.valid && out_chan.ready) begin
      got = '{out_chan.out_time, out_chan.out_azimuth, out_chan.out_slant_range,
              out_chan.out_elevation, out_chan.out_radial_speed,
              out_chan.out_probe_number, out_chan.out_point_id,
              out_chan.out_track_id, out_chan.lookup_status};
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected result", got.tm, '0);
      end else begin
        want = expected_words.pop_front();
        tv = typed_valid.pop_front();
        ts = typed_status.pop_front();
        if (tv && got.status !== ts) report_mismatch("typed status", got.status, ts);
        if (got.tm !== want.tm) report_mismatch("time", got.tm, want.tm);
        if (got.az !== want.az) report_mismatch("azimuth", got.az, want.az);
        if (got.sr !== want.sr) report_mismatch("slant range", got.sr, want.sr);
        if (got.el !== want.el) report_mismatch("elevation", got.el, want.el);
        if (got.rs !== want.rs) report_mismatch("radial speed", got.rs, want.rs);
        if (got.probe !== want.probe) report_mismatch("probe", got.probe, want.probe);
        if (got.point !== want.point) report_mismatch("point id", got.point, want.point);
        if (got.track !== want.track) report_mismatch("track id", got.track, want.track);
        if (got.status !== want.status) report_mismatch("status", got.status, want.status);
      end
    end
  end

  // Offers one word, with an optional idle burst first, and waits for acceptance.
  task automatic send_word(input word_in_t w, input logic tv, input logic [1:0] ts);
    word_out_t o;
    int gap;
    if (!no_stall && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 12);
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_chan.valid        <= 1'b1;
    in_chan.opcode       <= w.opcode;
    in_chan.entry_index  <= w.entry_index;
    in_chan.time_stamp   <= w.time_stamp;
    in_chan.azimuth      <= w.azimuth;
    in_chan.slant_range  <= w.slant_range;
    in_chan.elevation    <= w.elevation;
    in_chan.radial_speed <= w.radial_speed;
    in_chan.probe_number <= w.probe_number;
    in_chan.point_id     <= w.point_id;
    in_chan.track_id     <= w.track_id;
    do @(posedge clk_i); while (!in_chan.ready);
    if (lookup_predict(w, o)) begin
      expected_words.insert(expected_words.size(), o);
      typed_valid.insert(typed_valid.size(), tv);
      typed_status.insert(typed_status.size(), ts);
    end
  endtask

  // Waits for every result, then for the block to settle, before a register write.
  task automatic set_entry_count(input logic [10:0] val);
    in_chan.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (250) @(posedge clk_i);
    cfg_wr_en_i   <= 1'b1;
    cfg_wr_data_i <= val;
    @(posedge clk_i);
    cfg_wr_en_i <= 1'b0;
    count_in_use = val;
  endtask

  function automatic word_in_t random_word(logic op);
    word_in_t w;
    w = word_in_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                    $urandom, $urandom});
    w.opcode = op;
    return w;
  endfunction

  function automatic word_in_t load_word(int unsigned i, logic [31:0] t);
    word_in_t w;
    w = random_word(tsli_pkg::OPC_LOAD);
    w.entry_index = 10'(i);
    w.time_stamp = t;
    return w;
  endfunction

  function automatic word_in_t query_word(logic [31:0] t);
    word_in_t w;
    w = random_word(tsli_pkg::OPC_QUERY);
    w.time_stamp = t;
    return w;
  endfunction

  // Loads entries 0..n-1 with ascending random times, some of them equal.
  task automatic load_sorted_track(input int unsigned n, input int unsigned step);
    logic [31:0] t;
    t = $urandom_range(0, 1000);
    for (int unsigned i = 0; i < n; i++) begin
      send_word(load_word(i, t), 1'b0, tsli_pkg::ST_INTERP);
      if ($urandom_range(0, 7) != 0) t = t + $urandom_range(1, step);
    end
  endtask

  stim_row_t directed_rows[$];

  initial begin
    stim_row_t row;
    word_in_t w;
    int unsigned n, hi;
    in_chan.valid <= 1'b0;
    in_chan.opcode <= tsli_pkg::OPC_LOAD;
    in_chan.entry_index <= '0;
    in_chan.time_stamp <= '0;
    in_chan.azimuth <= '0;
    in_chan.slant_range <= '0;
    in_chan.elevation <= '0;
    in_chan.radial_speed <= '0;
    in_chan.probe_number <= '0;
    in_chan.point_id <= '0;
    in_chan.track_id <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table: single entry after reset, extremes, equal times, endpoints.
    directed_rows = '{
      '{0, 0, load_word(0, 32'd1000), 0, tsli_pkg::ST_INTERP},
      '{0, 0, query_word(32'd0), 1, tsli_pkg::ST_BELOW},
      '{0, 0, query_word(32'd1000), 1, tsli_pkg::ST_EXACT},
      '{0, 0, query_word(32'hffffffff), 1, tsli_pkg::ST_ABOVE},
      '{1, 11'd0, '0, 0, tsli_pkg::ST_INTERP},
      '{0, 0, query_word(32'd999), 1, tsli_pkg::ST_BELOW},
      '{0, 0, load_word(1, 32'd2000), 0, tsli_pkg::ST_INTERP},
      '{0, 0, load_word(2, 32'd2000), 0, tsli_pkg::ST_INTERP},
      '{0, 0, load_word(3, 32'hffffffff), 0, tsli_pkg::ST_INTERP},
      '{1, 11'd4, '0, 0, tsli_pkg::ST_INTERP},
      '{0, 0, query_word(32'd1000), 1, tsli_pkg::ST_EXACT},
      '{0, 0, query_word(32'hffffffff), 1, tsli_pkg::ST_EXACT},
      '{0, 0, query_word(32'd1500), 0, tsli_pkg::ST_INTERP},
      '{0, 0, query_word(32'd2000), 0, tsli_pkg::ST_INTERP},
      '{0, 0, query_word(32'd2001), 0, tsli_pkg::ST_INTERP},
      '{0, 0, query_word(32'h80000000), 0, tsli_pkg::ST_INTERP},
      '{0, 0, load_word(1023, 32'd5), 0, tsli_pkg::ST_INTERP},
      '{1, 11'd2047, '0, 0, tsli_pkg::ST_INTERP},
      '{0, 0, query_word(32'd5), 1, tsli_pkg::ST_BELOW},
      '{0, 0, query_word(32'd1001), 1, tsli_pkg::ST_ABOVE}
    };
    // Extreme values across entries 1 and 3.
    directed_rows[6].w.azimuth = 32'h80000000;
    directed_rows[6].w.slant_range = 32'h7fffffff;
    directed_rows[8].w.azimuth = 32'h7fffffff;
    directed_rows[8].w.slant_range = 32'h80000000;
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.is_cfg) set_entry_count(row.cfg_val);
      else send_word(row.w, row.has_status, row.status);
    end

    // Random phases: fresh sorted track, then mostly queries inside its span.
    for (int ph = 0; ph < 8; ph++) begin
      n = (ph == 7) ? 1024 : (ph == 0 ? 2 : $urandom_range(2, 40));
      set_entry_count(11'(n));
      load_sorted_track(n, (ph == 3) ? 32'h00ffffff : 5000);
      hi = track_time[n-1];
      if (ph == 5) no_stall = 1'b1;
      for (int i = 0; i < ((ph == 7) ? 60 : 120); i++) begin
        if (ph == 2 && i == 20) begin
          // Long receiver hold-off while words keep coming.
          fork
            begin
              hold_off = 1'b1;
              repeat (600) @(posedge clk_i);
              hold_off = 1'b0;
            end
          join_none
        end
        case ($urandom_range(0, 9))
          0: w = random_word(tsli_pkg::OPC_QUERY);
          1: w = query_word(track_time[$urandom_range(0, n-1)]);
          2: w = load_word($urandom_range(0, n-1), $urandom);
          default: w = query_word($urandom_range(track_time[0], hi));
        endcase
        send_word(w, 1'b0, tsli_pkg::ST_INTERP);
      end
    end
    set_entry_count(11'd1024);

    in_chan.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (mismatches == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
